>>> sv/pid_path_heading_control_core_assert.svh
// ----------------------------------------------------------------------------
// pid_path_heading_control_core_assert.svh
// Assertion macros for the path heading controller. Clock is clk, reset rst.
// ----------------------------------------------------------------------------
`ifndef PID_PATH_HEADING_CONTROL_CORE_ASSERT_SVH
`define PID_PATH_HEADING_CONTROL_CORE_ASSERT_SVH

// same-cycle implication
`define PIDHC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pidhc: same-cycle check failed");

// next-cycle implication
`define PIDHC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pidhc: next-cycle check failed");

`endif

>>> sv/pidhc_pkg.sv
// ----------------------------------------------------------------------------
// pidhc_pkg
// Shared widths, register indexes, angle constants and the CORDIC arctangent
// table for the path heading controller.
// ----------------------------------------------------------------------------
package pidhc_pkg;

  // CORDIC iterations, one cell each; at most 32 are used
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_CELLS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W       = 5;

  // field and datapath widths
  localparam int COORD_W = 16;
  localparam int ERR_W   = 17;
  localparam int INTEG_W = 16;
  localparam int DIFF_W  = 18;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 15;
  localparam int PROD_W  = 35;   // 17 bit signed gain x 18 bit signed operand
  localparam int ACC_W   = 37;   // sum of four products
  localparam int VEC_W   = 40;   // CORDIC x/y with growth headroom
  localparam int ANG_W   = 24;   // octant angle, 2^-16 degree units
  localparam int HANG_W  = 25;   // full-circle angle, 2^-16 degree units
  localparam int HEAD_W  = 9;
  localparam int IN_W    = 96;
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 3;

  // register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_PREVIEW    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_TARGET     = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEGRAL   = 3'd2;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIVATIVE = 3'd3;
  localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd4;

  // angle constants
  localparam logic signed [ANG_W-1:0]  ANGLE_45  = ANG_W'(45 * 65536);
  localparam logic signed [HANG_W-1:0] ANGLE_90  = HANG_W'(90 * 65536);
  localparam logic signed [HANG_W-1:0] ANGLE_180 = HANG_W'(180 * 65536);

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_preview;
    logic [GAIN_W-1:0]  gain_target;
    logic [GAIN_W-1:0]  gain_integral;
    logic [GAIN_W-1:0]  gain_derivative;
    logic [LIMIT_W-1:0] integral_limit;
  } cfg_t;

  // input word, first field in the highest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] goal_y;
    logic signed [COORD_W-1:0] goal_x;
    logic signed [COORD_W-1:0] preview_y;
    logic signed [COORD_W-1:0] preview_x;
  } in_t;

  // octant fold flags carried down the cell chain
  typedef struct packed {
    logic zero;     // both components zero
    logic axis;     // small component zero
    logic diag;     // components equal
    logic swapped;  // |y| > |x|
    logic neg_x;
    logic neg_y;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [ANG_W-1:0] z;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } cordic_t;

  // atan(2^-k) in 2^-16 degree units
  function automatic logic signed [ANG_W-1:0] cordic_atan(input logic [STEP_W-1:0] k);
    logic signed [ANG_W-1:0] a;
    case (k)
      5'd0:    a = ANG_W'(2949120);
      5'd1:    a = ANG_W'(1740967);
      5'd2:    a = ANG_W'(919879);
      5'd3:    a = ANG_W'(466945);
      5'd4:    a = ANG_W'(234379);
      5'd5:    a = ANG_W'(117304);
      5'd6:    a = ANG_W'(58666);
      5'd7:    a = ANG_W'(29335);
      5'd8:    a = ANG_W'(14668);
      5'd9:    a = ANG_W'(7334);
      5'd10:   a = ANG_W'(3667);
      5'd11:   a = ANG_W'(1833);
      5'd12:   a = ANG_W'(917);
      5'd13:   a = ANG_W'(458);
      5'd14:   a = ANG_W'(229);
      5'd15:   a = ANG_W'(115);
      5'd16:   a = ANG_W'(57);
      5'd17:   a = ANG_W'(29);
      5'd18:   a = ANG_W'(14);
      5'd19:   a = ANG_W'(7);
      5'd20:   a = ANG_W'(4);
      5'd21:   a = ANG_W'(2);
      5'd22:   a = ANG_W'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> sv/pid_path_heading_control_core.sv
// ----------------------------------------------------------------------------
// pid_path_heading_control_core
// Two-axis PID path follower with a CORDIC heading output in whole degrees.
// ----------------------------------------------------------------------------
// Takes one word of preview, goal and current position, updates the clamped
// per-axis integrals and previous target errors, forms the control vector
// with four multiply-accumulate passes on one multiplier per axis, folds it
// into the first octant and runs it down a chain of CORDIC_CELLS registered
// cells, one iteration each. s_tready stays low from the accepted word until
// its heading is loaded into the output register, so only one word is in
// flight at a time. The output register frees the input side, so a new word
// may be accepted while the last heading still waits downstream.
// Heading is floor(atan2) in degrees, -180..180, and 0 for a zero vector.
`include "pid_path_heading_control_core_assert.svh"

module pid_path_heading_control_core
  import pidhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // preview_x[15:0] preview_y[31:16] goal_x[47:32] goal_y[63:48]
  // pos_x[79:64] pos_y[95:80]
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // heading_deg[8:0], zero above
  output logic [OUT_W-1:0] m_tdata,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  cfg_t                    cfg;
  logic                    busy;
  logic                    accept;
  in_t                     word_in;

  logic                    vec_valid;
  logic signed [ACC_W-1:0] vec_x, vec_y;

  // fold stages
  logic                    f1_valid;
  logic [ACC_W-1:0]        f1_ax, f1_ay;
  logic                    f1_neg_x, f1_neg_y;
  logic                    f2_valid;
  cordic_t                 f2_data;
  logic                    f2_swap;
  logic [ACC_W-1:0]        f2_big, f2_small;

  // cell chain
  logic                    chain_valid [0:CORDIC_CELLS];
  cordic_t                 chain_data  [0:CORDIC_CELLS];
  logic                    end_valid;
  cordic_t                 end_data;

  // unfold
  logic signed [ANG_W-1:0]  z_clamped;
  logic signed [HANG_W-1:0] a_oct, a_swap, a_half, a_full;
  logic [HEAD_W-1:0]        heading;

  // output side
  logic                    out_free;
  logic                    pend_valid;
  logic [HEAD_W-1:0]       pend_heading;
  logic [HEAD_W-1:0]       out_heading;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign word_in  = in_t'(s_tdata);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_preview    <= GAIN_W'(256);
      cfg.gain_target     <= GAIN_W'(256);
      cfg.gain_integral   <= '0;
      cfg.gain_derivative <= '0;
      cfg.integral_limit  <= LIMIT_W'(100);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_PREVIEW:    cfg.gain_preview    <= cfg_data;
        REG_GAIN_TARGET:     cfg.gain_target     <= cfg_data;
        REG_GAIN_INTEGRAL:   cfg.gain_integral   <= cfg_data;
        REG_GAIN_DERIVATIVE: cfg.gain_derivative <= cfg_data;
        REG_INTEGRAL_LIMIT:  cfg.integral_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  pidhc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .word_in   (word_in),
    .cfg       (cfg),
    .vec_valid (vec_valid),
    .vec_x     (vec_x),
    .vec_y     (vec_y)
  );

  // fold 1: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= vec_valid;
    end
  end

  always_ff @(posedge clk) begin
    f1_ax    <= vec_x[ACC_W-1] ? ACC_W'(-vec_x) : ACC_W'(vec_x);
    f1_ay    <= vec_y[ACC_W-1] ? ACC_W'(-vec_y) : ACC_W'(vec_y);
    f1_neg_x <= vec_x[ACC_W-1];
    f1_neg_y <= vec_y[ACC_W-1];
  end

  // fold 2: swap into the first octant, note the exact cases
  always_comb begin
    f2_swap  = f1_ay > f1_ax;
    f2_big   = f2_swap ? f1_ay : f1_ax;
    f2_small = f2_swap ? f1_ax : f1_ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    f2_data.x            <= {{(VEC_W-ACC_W){1'b0}}, f2_big};
    f2_data.y            <= {{(VEC_W-ACC_W){1'b0}}, f2_small};
    f2_data.z            <= '0;
    f2_data.side.zero    <= (f2_big == '0);
    f2_data.side.axis    <= (f2_small == '0);
    f2_data.side.diag    <= (f2_small == f2_big);
    f2_data.side.swapped <= f2_swap;
    f2_data.side.neg_x   <= f1_neg_x;
    f2_data.side.neg_y   <= f1_neg_y;
  end

  // CORDIC cell chain
  assign chain_valid[0] = f2_valid;
  assign chain_data[0]  = f2_data;

  for (genvar i = 0; i < CORDIC_CELLS; i++) begin : g_cell
    pidhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(i)),
      .valid_in  (chain_valid[i]),
      .data_in   (chain_data[i]),
      .valid_out (chain_valid[i+1]),
      .data_out  (chain_data[i+1])
    );
  end

  assign end_valid = chain_valid[CORDIC_CELLS];
  assign end_data  = chain_data[CORDIC_CELLS];

  // unfold to the full circle and floor to degrees
  always_comb begin
    if (end_data.z[ANG_W-1]) begin
      z_clamped = '0;
    end else if (end_data.z > ANGLE_45) begin
      z_clamped = ANGLE_45;
    end else begin
      z_clamped = end_data.z;
    end
    if (end_data.side.axis) begin
      a_oct = '0;
    end else if (end_data.side.diag) begin
      a_oct = HANG_W'(ANGLE_45);
    end else begin
      a_oct = HANG_W'(z_clamped);
    end
    a_swap  = end_data.side.swapped ? ANGLE_90 - a_oct : a_oct;
    a_half  = end_data.side.neg_x ? ANGLE_180 - a_swap : a_swap;
    a_full  = end_data.side.neg_y ? -a_half : a_half;
    heading = end_data.side.zero ? '0 : a_full[HANG_W-1:HANG_W-HEAD_W];
  end

  // output register with one holding slot
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (pend_valid && out_free) begin
        m_tvalid   <= 1'b1;
        pend_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (end_valid && out_free) begin
        m_tvalid <= 1'b1;
        busy     <= 1'b0;
      end else if (end_valid) begin
        pend_valid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_free) begin
      out_heading <= pend_heading;
    end else if (end_valid && out_free) begin
      out_heading <= heading;
    end
    if (end_valid && !out_free) begin
      pend_heading <= heading;
    end
  end

  assign m_tdata = {{(OUT_W-HEAD_W){1'b0}}, out_heading};

  // checks
  `PIDHC_ASSERT_IMPL(a_pend_behind_out, pend_valid, m_tvalid && busy)
  `PIDHC_ASSERT_IMPL(a_chain_end_busy, end_valid, busy && !pend_valid)
  `PIDHC_ASSERT_IMPL(a_vector_busy, vec_valid, busy)
  `PIDHC_ASSERT_NEXT(a_accept_holds, s_tvalid && s_tready, busy)

endmodule

>>> sv/pidhc_cell.sv
// ----------------------------------------------------------------------------
// pidhc_cell
// One vectoring CORDIC iteration as a registered cell. The step index is tied
// off per instance, so the shifts and the arctangent fold to constants.
// ----------------------------------------------------------------------------
module pidhc_cell
  import pidhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [STEP_W-1:0] step,
  input  logic              valid_in,
  input  cordic_t           data_in,
  output logic              valid_out,
  output cordic_t           data_out
);

  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  logic signed [ANG_W-1:0] ang;
  cordic_t                 data_next;

  // rotate towards y = 0
  always_comb begin
    dx        = data_in.y >>> step;
    dy        = data_in.x >>> step;
    ang       = cordic_atan(step);
    data_next = data_in;
    if (!data_in.y[VEC_W-1]) begin
      data_next.x = data_in.x + dx;
      data_next.y = data_in.y - dy;
      data_next.z = data_in.z + ang;
    end else begin
      data_next.x = data_in.x - dx;
      data_next.y = data_in.y + dy;
      data_next.z = data_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_out <= data_next;
  end

endmodule

>>> sv/pidhc_front.sv
// ----------------------------------------------------------------------------
// pidhc_front
// Error terms, clamped integrals and derivative per axis, then the control
// vector from four multiply-accumulate passes on one multiplier per axis.
// ----------------------------------------------------------------------------
module pidhc_front
  import pidhc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  in_t                     word_in,
  input  cfg_t                    cfg,
  output logic                    vec_valid,
  output logic signed [ACC_W-1:0] vec_x,
  output logic signed [ACC_W-1:0] vec_y
);

  // multiply pass codes
  localparam logic [1:0] PH_PREVIEW    = 2'd0;
  localparam logic [1:0] PH_TARGET     = 2'd1;
  localparam logic [1:0] PH_INTEGRAL   = 2'd2;
  localparam logic [1:0] PH_DERIVATIVE = 2'd3;

  // axis state
  logic signed [INTEG_W-1:0] integ_x, integ_y;
  logic signed [ERR_W-1:0]   prev_x, prev_y;

  // operands of the current word
  logic signed [ERR_W-1:0]   ep_x, ep_y, et_x, et_y;
  logic signed [DIFF_W-1:0]  d_x, d_y;

  // sequencer
  logic                      running;
  logic [1:0]                phase;
  logic                      prod_valid, prod_last;
  logic signed [PROD_W-1:0]  prod_x, prod_y;

  // combinational front terms
  logic signed [ERR_W-1:0]   ep_x_next, ep_y_next, et_x_next, et_y_next;
  logic signed [DIFF_W-1:0]  lim, sum_x, sum_y;
  logic signed [INTEG_W-1:0] integ_x_next, integ_y_next;

  // operand select and multiply
  logic [GAIN_W-1:0]         gain;
  logic signed [DIFF_W-1:0]  opd_x, opd_y;
  logic signed [PROD_W-1:0]  mul_x, mul_y;

  function automatic logic signed [INTEG_W-1:0] clamp_integ(
    input logic signed [DIFF_W-1:0] v,
    input logic signed [DIFF_W-1:0] l
  );
    logic signed [DIFF_W-1:0] r;
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[INTEG_W-1:0];
  endfunction

  // errors and integral update
  always_comb begin
    ep_x_next = ERR_W'(word_in.preview_x) - ERR_W'(word_in.pos_x);
    ep_y_next = ERR_W'(word_in.preview_y) - ERR_W'(word_in.pos_y);
    et_x_next = ERR_W'(word_in.goal_x) - ERR_W'(word_in.pos_x);
    et_y_next = ERR_W'(word_in.goal_y) - ERR_W'(word_in.pos_y);
    lim       = {{(DIFF_W-LIMIT_W){1'b0}}, cfg.integral_limit};
    sum_x     = DIFF_W'(integ_x) + DIFF_W'(et_x_next);
    sum_y     = DIFF_W'(integ_y) + DIFF_W'(et_y_next);
    integ_x_next = clamp_integ(sum_x, lim);
    integ_y_next = clamp_integ(sum_y, lim);
  end

  // gain and operand for this pass
  always_comb begin
    gain  = cfg.gain_preview;
    opd_x = DIFF_W'(ep_x);
    opd_y = DIFF_W'(ep_y);
    case (phase)
      PH_PREVIEW: begin
        gain  = cfg.gain_preview;
        opd_x = DIFF_W'(ep_x);
        opd_y = DIFF_W'(ep_y);
      end
      PH_TARGET: begin
        gain  = cfg.gain_target;
        opd_x = DIFF_W'(et_x);
        opd_y = DIFF_W'(et_y);
      end
      PH_INTEGRAL: begin
        gain  = cfg.gain_integral;
        opd_x = DIFF_W'(integ_x);
        opd_y = DIFF_W'(integ_y);
      end
      PH_DERIVATIVE: begin
        gain  = cfg.gain_derivative;
        opd_x = d_x;
        opd_y = d_y;
      end
      default: begin
        gain  = cfg.gain_preview;
        opd_x = DIFF_W'(ep_x);
        opd_y = DIFF_W'(ep_y);
      end
    endcase
  end

  assign mul_x = $signed({1'b0, gain}) * opd_x;
  assign mul_y = $signed({1'b0, gain}) * opd_y;

  // axis state and sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      integ_x    <= '0;
      integ_y    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      running    <= 1'b0;
      phase      <= PH_PREVIEW;
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      vec_valid  <= 1'b0;
    end else begin
      prod_valid <= 1'b0;
      prod_last  <= 1'b0;
      vec_valid  <= prod_valid && prod_last;
      if (start) begin
        integ_x <= integ_x_next;
        integ_y <= integ_y_next;
        prev_x  <= et_x_next;
        prev_y  <= et_y_next;
        running <= 1'b1;
        phase   <= PH_PREVIEW;
      end else if (running) begin
        prod_valid <= 1'b1;
        phase      <= phase + 2'd1;
        if (phase == PH_DERIVATIVE) begin
          prod_last <= 1'b1;
          running   <= 1'b0;
        end
      end
    end
  end

  // operands, products and accumulators
  always_ff @(posedge clk) begin
    if (start) begin
      ep_x  <= ep_x_next;
      ep_y  <= ep_y_next;
      et_x  <= et_x_next;
      et_y  <= et_y_next;
      d_x   <= DIFF_W'(et_x_next) - DIFF_W'(prev_x);
      d_y   <= DIFF_W'(et_y_next) - DIFF_W'(prev_y);
      vec_x <= '0;
      vec_y <= '0;
    end else if (prod_valid) begin
      vec_x <= vec_x + {{(ACC_W-PROD_W){prod_x[PROD_W-1]}}, prod_x};
      vec_y <= vec_y + {{(ACC_W-PROD_W){prod_y[PROD_W-1]}}, prod_y};
    end
    prod_x <= mul_x;
    prod_y <= mul_y;
  end

endmodule
